FILE: hdl/ljpf_pkg.sv
// Shared types, codes and constants for the Lennard-Jones pair force block.
package ljpf_pkg;

    localparam int CoordBits  = 32;
    localparam int IndexBits  = 16;
    localparam int CfgBits    = 31;
    localparam int ForceBits  = 48;
    localparam int WordBits   = 64;
    localparam int ProdBits   = 128;
    localparam int QuoBits    = 57;

    localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Lim48    = Int64Max / 48;
    localparam logic [63:0] Lim24    = Int64Max / 24;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_FACT,
        ST_VADD,
        ST_OUT
    } t_state;

    // Multiplier operations, in issue order
    typedef enum logic [3:0] {
        OP_SQX,
        OP_SQY,
        OP_SQZ,
        OP_RC,
        OP_R4,
        OP_R6,
        OP_R8,
        OP_R14,
        OP_FX,
        OP_FY,
        OP_FZ,
        OP_VIR
    } t_op;

    // Configuration register indexes
    typedef enum logic {
        REG_BOX_LENGTH    = 1'b0,
        REG_CUTOFF_RADIUS = 1'b1
    } t_reg;

    // Request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

endpackage

FILE: hdl/lj_pair_force_periodic.sv
// Lennard-Jones pair force with minimum-image wrap: sequencer and top level.
// An in-range pair takes one divider pass plus twelve passes of the shared
// multiplier, an out-of-range pair four multiplier passes and no divider pass,
// and a pair with a wrapped component of magnitude 2^31 or more neither. One
// pair at a time; ready returns in the cycle after the result is registered, later
// while a result beat waits. Reset (synchronous, active low) loads box 10.0, cutoff 2.5.
module lj_pair_force_periodic
    import ljpf_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [CfgBits-1:0]          i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [CoordBits-1:0] i_first_x,
    input  logic signed [CoordBits-1:0] i_first_y,
    input  logic signed [CoordBits-1:0] i_first_z,
    input  logic signed [CoordBits-1:0] i_second_x,
    input  logic signed [CoordBits-1:0] i_second_y,
    input  logic signed [CoordBits-1:0] i_second_z,
    input  logic [IndexBits-1:0]        i_first_index,
    input  logic [IndexBits-1:0]        i_second_index,
    input  logic                        i_first_pair,
    input  logic                        i_last_pair,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [IndexBits-1:0]        o_out_first_index,
    output logic [IndexBits-1:0]        o_out_second_index,
    output logic signed [ForceBits-1:0] o_force_x,
    output logic signed [ForceBits-1:0] o_force_y,
    output logic signed [ForceBits-1:0] o_force_z,
    output logic                        o_in_range,
    output logic signed [WordBits-1:0]  o_virial_sum,
    output logic                        o_out_last
);

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_issued;

    logic [CfgBits-1:0]          r_box, r_cut;
    logic signed [31:0]          r_dx, r_dy, r_dz;
    logic [30:0]                 r_ax, r_ay, r_az;
    logic                        r_far;
    logic [63:0]                 r_rsq, r_rcsq;
    logic                        r_inr;
    logic [63:0]                 r_r2, r_r4, r_r6, r_r8, r_r14;
    logic signed [63:0]          r_f;
    logic [63:0]                 r_fabs;
    logic signed [ForceBits-1:0] r_fx, r_fy, r_fz;
    logic signed [63:0]          r_term, r_acc;
    logic [IndexBits-1:0]        r_fi, r_si;
    logic                        r_fp, r_lp;

    logic                        r_oval;
    logic [IndexBits-1:0]        r_o_fi, r_o_si;
    logic signed [ForceBits-1:0] r_o_fx, r_o_fy, r_o_fz;
    logic                        r_o_inr, r_o_last;
    logic signed [63:0]          r_o_vir;

    t_mul_req            s_mreq;
    logic                s_mdone;
    logic [ProdBits-1:0] s_prod;
    logic                s_dstart, s_ddone;
    logic [QuoBits-1:0]  s_quot;
    logic                s_load, s_far;
    logic signed [33:0]  s_wx, s_wy, s_wz;
    logic [63:0]         s_r24;
    logic [111:0]        s_q16;
    logic [95:0]         s_q32;
    logic [ForceBits-1:0] s_fmag;
    logic signed [ForceBits-1:0] s_fval;
    logic                s_fneg;
    logic [63:0]         s_vmag;
    logic signed [63:0]  s_vval;
    logic signed [63:0]  s_fnew, s_b24;
    logic signed [64:0]  s_vsum;

    // minimum-image wrap of one axis, 34-bit signed result
    function automatic logic signed [33:0] wrap_axis(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic [CfgBits-1:0] len
    );
        logic signed [34:0] v;
        logic signed [34:0] l;
        logic signed [34:0] r;
        v = 35'(a) - 35'(b);
        l = 35'({4'd0, len});
        if ((v <<< 1) < -l)     r = v + l;
        else if ((v <<< 1) > l) r = v - l;
        else                    r = v;
        return r[33:0];
    endfunction

    function automatic logic too_far(input logic signed [33:0] v);
        return (v >= 34'sh0_8000_0000) || (v <= -34'sh0_8000_0000);
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m[30:0];
    endfunction

    assign s_wx  = wrap_axis(i_first_x, i_second_x, r_box);
    assign s_wy  = wrap_axis(i_first_y, i_second_y, r_box);
    assign s_wz  = wrap_axis(i_first_z, i_second_z, r_box);
    assign s_far = too_far(s_wx) || too_far(s_wy) || too_far(s_wz);

    // shared units
    ljpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_mreq),
        .o_done  (s_mdone),
        .o_prod  (s_prod)
    );

    ljpf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_dstart),
        .i_divisor (r_rsq),
        .o_done    (s_ddone),
        .o_quot    (s_quot)
    );

    // multiplier operand select
    always_comb begin
        s_mreq.start = (r_state == ST_MUL) && !r_issued;
        unique case (r_op)
            OP_SQX:  begin s_mreq.a = 64'(r_ax);   s_mreq.b = 64'(r_ax);  end
            OP_SQY:  begin s_mreq.a = 64'(r_ay);   s_mreq.b = 64'(r_ay);  end
            OP_SQZ:  begin s_mreq.a = 64'(r_az);   s_mreq.b = 64'(r_az);  end
            OP_RC:   begin s_mreq.a = 64'(r_cut);  s_mreq.b = 64'(r_cut); end
            OP_R4:   begin s_mreq.a = r_r2;        s_mreq.b = r_r2;       end
            OP_R6:   begin s_mreq.a = r_r4;        s_mreq.b = r_r2;       end
            OP_R8:   begin s_mreq.a = r_r6;        s_mreq.b = r_r2;       end
            OP_R14:  begin s_mreq.a = r_r8;        s_mreq.b = r_r6;       end
            OP_FX:   begin s_mreq.a = 64'(r_ax);   s_mreq.b = r_fabs;     end
            OP_FY:   begin s_mreq.a = 64'(r_ay);   s_mreq.b = r_fabs;     end
            OP_FZ:   begin s_mreq.a = 64'(r_az);   s_mreq.b = r_fabs;     end
            OP_VIR:  begin s_mreq.a = r_fabs;      s_mreq.b = r_rsq;      end
            default: begin s_mreq.a = '0;          s_mreq.b = '0;         end
        endcase
    end

    assign s_dstart = (r_state == ST_DIV) && !r_issued;

    // product scaling and saturation
    assign s_r24 = (|s_prod[127:88]) ? '1 : s_prod[87:24];
    assign s_q16 = s_prod[127:16];
    assign s_q32 = s_prod[127:32];

    always_comb begin
        unique case (r_op)
            OP_FX:   s_fneg = r_dx[31] ^ r_f[63];
            OP_FY:   s_fneg = r_dy[31] ^ r_f[63];
            default: s_fneg = r_dz[31] ^ r_f[63];
        endcase
    end

    always_comb begin
        if (s_fneg) begin
            s_fmag = (s_q16 > 112'h8000_0000_0000) ? 48'h8000_0000_0000 : s_q16[47:0];
            s_fval = -$signed(s_fmag);
        end else begin
            s_fmag = (s_q16 > 112'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : s_q16[47:0];
            s_fval = $signed(s_fmag);
        end
        if (r_f[63]) begin
            s_vmag = (s_q32 > {32'd0, Int64Max + 64'd1}) ? Int64Max + 64'd1 : s_q32[63:0];
            s_vval = -$signed(s_vmag);
        end else begin
            s_vmag = (s_q32 > {32'd0, Int64Max}) ? Int64Max : s_q32[63:0];
            s_vval = $signed(s_vmag);
        end
    end

    // force factor 48 r^-14 - 24 r^-8
    always_comb begin
        s_b24 = (r_r8 > Lim24) ? $signed(Int64Max) : $signed((r_r8 << 4) + (r_r8 << 3));
        if (r_r14 > Lim48) s_fnew = $signed(Int64Max);
        else               s_fnew = $signed((r_r14 << 5) + (r_r14 << 4)) - s_b24;
    end

    assign s_vsum = 65'(r_acc) + 65'(r_term);
    assign s_load = (r_state == ST_OUT) && (!r_oval || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_WRAP;
            ST_WRAP:  n_state = r_far ? ST_CHECK : ST_MUL;
            ST_MUL: begin
                if (s_mdone) begin
                    unique case (r_op)
                        OP_RC:   n_state = ST_CHECK;
                        OP_R14:  n_state = ST_FACT;
                        OP_VIR:  n_state = ST_VADD;
                        default: n_state = ST_MUL;
                    endcase
                end
            end
            ST_CHECK: n_state = ((r_rsq != 64'd0) && (r_rsq < r_rcsq)) ? ST_DIV : ST_OUT;
            ST_DIV:   if (s_ddone) n_state = ST_MUL;
            ST_FACT:  n_state = ST_MUL;
            ST_VADD:  n_state = ST_OUT;
            ST_OUT:   if (s_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = r_oval;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_op     <= OP_SQX;
            r_box    <= 31'd655360;
            r_cut    <= 31'd163840;
            r_acc    <= '0;
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_BOX_LENGTH:    r_box <= i_cfg_data;
                    REG_CUTOFF_RADIUS: r_cut <= i_cfg_data;
                    default:           r_box <= r_box;
                endcase
            end
            if (s_mreq.start || s_dstart) r_issued <= 1'b1;
            else if (s_mdone || s_ddone)  r_issued <= 1'b0;
            if (r_state == ST_WRAP)           r_op <= OP_SQX;
            else if (r_state == ST_DIV)       r_op <= OP_R4;
            else if (r_state == ST_FACT)      r_op <= OP_FX;
            else if (s_mdone && r_op != OP_VIR) r_op <= t_op'(r_op + 4'd1);
            if (r_state == ST_CHECK && r_fp) r_acc <= '0;
            if (r_state == ST_VADD) begin
                if (r_acc[63] == r_term[63] && s_vsum[63] != r_acc[63])
                    r_acc <= r_acc[63] ? $signed(~Int64Max) : $signed(Int64Max);
                else
                    r_acc <= s_vsum[63:0];
            end
            if (s_load)       r_oval <= 1'b1;
            else if (i_ready) r_oval <= 1'b0;
        end
    end

    // datapath registers; the wrap is captured with the input beat
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_fi  <= i_first_index;
            r_si  <= i_second_index;
            r_fp  <= i_first_pair;
            r_lp  <= i_last_pair;
            r_dx  <= s_wx[31:0];
            r_dy  <= s_wy[31:0];
            r_dz  <= s_wz[31:0];
            r_ax  <= mag31(s_wx[31:0]);
            r_ay  <= mag31(s_wy[31:0]);
            r_az  <= mag31(s_wz[31:0]);
            r_far <= s_far;
        end
        if (r_state == ST_WRAP) begin
            r_rsq <= '0;
            r_fx  <= '0;
            r_fy  <= '0;
            r_fz  <= '0;
        end
        if (r_state == ST_CHECK) r_inr <= (r_rsq != 64'd0) && (r_rsq < r_rcsq);
        if (s_ddone) r_r2 <= 64'(s_quot);
        if (r_state == ST_FACT) begin
            r_f    <= s_fnew;
            r_fabs <= s_fnew[63] ? 64'(-s_fnew) : 64'(s_fnew);
        end
        if (s_mdone) begin
            unique case (r_op)
                OP_SQX, OP_SQY, OP_SQZ: r_rsq <= r_rsq + s_prod[63:0];
                OP_RC:   r_rcsq <= s_prod[63:0];
                OP_R4:   r_r4   <= s_r24;
                OP_R6:   r_r6   <= s_r24;
                OP_R8:   r_r8   <= s_r24;
                OP_R14:  r_r14  <= s_r24;
                OP_FX:   r_fx   <= s_fval;
                OP_FY:   r_fy   <= s_fval;
                OP_FZ:   r_fz   <= s_fval;
                default: r_term <= s_vval;
            endcase
        end
        if (s_load) begin
            r_o_fi   <= r_fi;
            r_o_si   <= r_si;
            r_o_fx   <= r_fx;
            r_o_fy   <= r_fy;
            r_o_fz   <= r_fz;
            r_o_inr  <= r_inr;
            r_o_vir  <= r_acc;
            r_o_last <= r_lp;
        end
    end

    assign o_out_first_index  = r_o_fi;
    assign o_out_second_index = r_o_si;
    assign o_force_x          = r_o_fx;
    assign o_force_y          = r_o_fy;
    assign o_force_z          = r_o_fz;
    assign o_in_range         = r_o_inr;
    assign o_virial_sum       = r_o_vir;
    assign o_out_last         = r_o_last;

    // out-of-range beats carry zero force
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_force_x == '0 && o_force_y == '0 && o_force_z == '0))
        else $error("nonzero force on out-of-range beat");

    // the two shared units never finish together
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_mdone && s_ddone))
        else $error("multiplier and divider finished together");

    // an accepted pair starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_WRAP))
        else $error("accepted pair did not start");

endmodule

FILE: hdl/ljpf_mul.sv
// Shared 64x64 multiplier built from one 32x32 unit, summing its partial products in turn.
module ljpf_mul
    import ljpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mul_req            i_req,
    output logic                o_done,
    output logic [ProdBits-1:0] o_prod
);

    logic [63:0]         r_a, r_b;
    logic [1:0]          r_step;
    logic                r_busy, r_done;
    logic [ProdBits-1:0] r_acc;
    logic [31:0]         s_opa, s_opb;
    logic [63:0]         s_pp;
    logic [ProdBits-1:0] s_shift;

    // operand halves for this step
    assign s_opa = r_step[0] ? r_a[63:32] : r_a[31:0];
    assign s_opb = r_step[1] ? r_b[63:32] : r_b[31:0];
    assign s_pp  = s_opa * s_opb;

    // align the partial product
    always_comb begin
        unique case ({1'b0, r_step[0]} + {1'b0, r_step[1]})
            2'd0:    s_shift = {64'd0, s_pp};
            2'd1:    s_shift = {32'd0, s_pp, 32'd0};
            default: s_shift = {s_pp, 64'd0};
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + s_shift;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: hdl/ljpf_div.sv
// Restoring divider: 2^56 / divisor, one quotient bit per cycle.
module ljpf_div
    import ljpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_divisor,
    output logic               o_done,
    output logic [QuoBits-1:0] o_quot
);

    logic [63:0]        r_div;
    logic [64:0]        r_rem;
    logic [QuoBits-1:0] r_quot;
    logic [5:0]         r_cnt;
    logic               r_busy, r_done;
    logic [64:0]        s_trial;
    logic               s_ge;

    // next remainder bit: the dividend has a single one at its top
    assign s_trial = {r_rem[63:0], (r_cnt == 6'(QuoBits - 1))};
    assign s_ge    = s_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QuoBits - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= s_ge ? s_trial - {1'b0, r_div} : s_trial;
            r_quot <= {r_quot[QuoBits-2:0], s_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: test/lj_pair_force_periodic_tb.sv
// Testbench for the Lennard-Jones pair force block: directed, random, backpressure and streaming tests.
module lj_pair_force_periodic_tb;
    import ljpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ForceCap = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [30:0] CfgMax   = 31'h7FFF_FFFF;

    typedef struct {
        logic signed [CoordBits-1:0] ax, ay, az, bx, by, bz;
        logic [IndexBits-1:0]        a_idx, b_idx;
        logic                        first, last;
    } t_pair;

    typedef struct {
        logic [IndexBits-1:0] a_idx, b_idx;
        logic [ForceBits-1:0] fx, fy, fz;
        logic                 hit;
        logic [WordBits-1:0]  virial;
        logic                 last;
    } t_force;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CfgBits-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CoordBits-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
    logic [IndexBits-1:0] a_idx = '0, b_idx = '0;
    logic first_pair = 1'b0, last_pair = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [IndexBits-1:0] o_a_idx, o_b_idx;
    logic signed [ForceBits-1:0] o_fx, o_fy, o_fz;
    logic o_hit;
    logic signed [WordBits-1:0] o_virial;
    logic o_last;

    // predictor state
    logic [30:0] box_len = 31'd655360;
    logic [30:0] cut_rad = 31'd163840;
    logic signed [63:0] virial_acc = '0;
    t_force force_q[$];

    int errors = 0;
    bit no_idle = 1'b0;
    bit hold_rx = 1'b0;

    always #2 clk = ~clk;

    lj_pair_force_periodic u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_first_x(ax), .i_first_y(ay), .i_first_z(az),
        .i_second_x(bx), .i_second_y(by), .i_second_z(bz),
        .i_first_index(a_idx), .i_second_index(b_idx),
        .i_first_pair(first_pair), .i_last_pair(last_pair),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_out_first_index(o_a_idx), .o_out_second_index(o_b_idx),
        .o_force_x(o_fx), .o_force_y(o_fy), .o_force_z(o_fz),
        .o_in_range(o_hit), .o_virial_sum(o_virial), .o_out_last(o_last)
    );

    // (a * b) >> sh, clamped to cap
    function automatic logic [63:0] mul_shift_clamp(logic [63:0] a, logic [63:0] b, int sh,
                                                    logic [63:0] cap);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> sh;
        if (p > {64'b0, cap}) return cap;
        return p[63:0];
    endfunction

    // signed product, magnitude truncated, clamped to [-cap-1, cap]
    function automatic logic [63:0] signed_product(longint a, longint b, int sh,
                                                   logic [63:0] cap);
        logic neg;
        logic [63:0] ua, ub, mag;
        if (a == 0 || b == 0) return '0;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        mag = mul_shift_clamp(ua, ub, sh, neg ? cap + 64'd1 : cap);
        if (!neg) return mag;
        if (mag > cap) return -cap - 64'd1;
        return -mag;
    endfunction

    // expected result of one pair; advances the virial sum
    function automatic t_force predict_pair(t_pair p);
        t_force r;
        longint d[3], lbox, v, f, term;
        logic [63:0] rsq, rcsq, m, r2, r4, r6, r8, r14, b24;
        logic hit;
        lbox = box_len;
        d[0] = longint'(p.ax) - longint'(p.bx);
        d[1] = longint'(p.ay) - longint'(p.by);
        d[2] = longint'(p.az) - longint'(p.bz);
        hit = 1'b1;
        rsq = '0;
        r.fx = '0; r.fy = '0; r.fz = '0;
        for (int k = 0; k < 3; k++) begin
            v = d[k];
            if (2 * v < -lbox) v += lbox;
            else if (2 * v > lbox) v -= lbox;
            d[k] = v;
            if (v >= 64'sd2147483648 || v <= -64'sd2147483648) hit = 1'b0;
        end
        if (hit) begin
            for (int k = 0; k < 3; k++) begin
                m = (d[k] < 0) ? -d[k] : d[k];
                rsq += m * m;
            end
            rcsq = {33'b0, cut_rad} * {33'b0, cut_rad};
            hit = (rsq != 0) && (rsq < rcsq);
        end
        if (p.first) virial_acc = '0;
        if (hit) begin
            r2  = (64'd1 << 56) / rsq;
            r4  = mul_shift_clamp(r2, r2, 24, '1);
            r6  = mul_shift_clamp(r4, r2, 24, '1);
            r8  = mul_shift_clamp(r6, r2, 24, '1);
            r14 = mul_shift_clamp(r8, r6, 24, '1);
            if (r14 > Lim48) begin
                f = Int64Max;
            end else begin
                b24 = (r8 > Lim24) ? Int64Max : r8 * 24;
                f = longint'(r14 * 48) - longint'(b24);
            end
            r.fx = 48'(signed_product(d[0], f, 16, ForceCap));
            r.fy = 48'(signed_product(d[1], f, 16, ForceCap));
            r.fz = 48'(signed_product(d[2], f, 16, ForceCap));
            term = signed_product(f, longint'(rsq), 32, Int64Max);
            if (term > 0 && virial_acc > longint'(Int64Max) - term)
                virial_acc = Int64Max;
            else if (term < 0 && virial_acc < -longint'(Int64Max) - 1 - term)
                virial_acc = {1'b1, 63'b0};
            else
                virial_acc += term;
        end
        r.a_idx = p.a_idx;
        r.b_idx = p.b_idx;
        r.hit = hit;
        r.virial = virial_acc;
        r.last = p.last;
        return r;
    endfunction

    // predict on every accepted input beat
    always @(posedge clk) begin
        t_pair p;
        if (rst_n && in_valid && in_ready) begin
            p = '{ax, ay, az, bx, by, bz, a_idx, b_idx, first_pair, last_pair};
            force_q.push_back(predict_pair(p));
        end
    end

    // compare every accepted output beat with the oldest prediction
    always @(posedge clk) begin
        t_force e;
        if (rst_n && out_valid && out_ready) begin
            if (force_q.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                e = force_q.pop_front();
                if (o_a_idx !== e.a_idx) begin
                    $display("%0t: first_index exp %h got %h", $time, e.a_idx, o_a_idx);
                    errors++;
                end
                if (o_b_idx !== e.b_idx) begin
                    $display("%0t: second_index exp %h got %h", $time, e.b_idx, o_b_idx);
                    errors++;
                end
                if (o_fx !== e.fx) begin
                    $display("%0t: force_x exp %h got %h", $time, e.fx, o_fx);
                    errors++;
                end
                if (o_fy !== e.fy) begin
                    $display("%0t: force_y exp %h got %h", $time, e.fy, o_fy);
                    errors++;
                end
                if (o_fz !== e.fz) begin
                    $display("%0t: force_z exp %h got %h", $time, e.fz, o_fz);
                    errors++;
                end
                if (o_hit !== e.hit) begin
                    $display("%0t: in_range exp %b got %b", $time, e.hit, o_hit);
                    errors++;
                end
                if (o_virial !== e.virial) begin
                    $display("%0t: virial exp %h got %h", $time, e.virial, o_virial);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last exp %b got %b", $time, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls per beat, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_rx) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // send one pair; valid stays high across back-to-back beats
    task automatic send_pair(t_pair p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        {ax, ay, az, bx, by, bz} <= {p.ax, p.ay, p.az, p.bx, p.by, p.bz};
        a_idx <= p.a_idx;
        b_idx <= p.b_idx;
        first_pair <= p.first;
        last_pair <= p.last;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // drain, then write one register while the block is idle
    task automatic write_reg(t_reg idx, logic [30:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (force_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BOX_LENGTH) box_len = val;
        else cut_rad = val;
    endtask

    function automatic t_pair make_pair(logic signed [31:0] a0, logic signed [31:0] a1,
                                        logic signed [31:0] a2, logic signed [31:0] b0,
                                        logic signed [31:0] b1, logic signed [31:0] b2,
                                        logic fp, logic lp);
        t_pair p;
        p = '{a0, a1, a2, b0, b1, b2, 16'($urandom), 16'($urandom), fp, lp};
        return p;
    endfunction

    // random pair: mostly near neighbors, some across the boundary, some noise
    function automatic t_pair random_pair(logic fp, logic lp, int reach);
        t_pair p;
        logic signed [31:0] base[3], off[3];
        int mode;
        mode = $urandom_range(0, 9);
        p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, fp, lp);
        if (mode < 8) begin
            for (int k = 0; k < 3; k++) begin
                base[k] = $urandom;
                off[k] = $signed($urandom_range(0, 2 * reach)) - reach;
                if (mode == 7 && $urandom_range(0, 1)) off[k] += 32'(box_len);
            end
            p.ax = base[0]; p.ay = base[1]; p.az = base[2];
            p.bx = base[0] + off[0]; p.by = base[1] + off[1]; p.bz = base[2] + off[2];
        end
        return p;
    endfunction

    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1, 0));                  // zero distance
        send_pair(make_pair(mx, mx, mx, mn, mn, mn, 0, 0));            // far separation
        send_pair(make_pair(mn, mn, mn, mx, mx, mx, 0, 0));
        send_pair(make_pair(65536, 0, 0, 0, 0, 0, 0, 0));              // r = 1
        send_pair(make_pair(0, 73400, 0, 0, 0, 0, 0, 0));              // near minimum
        send_pair(make_pair(0, 0, 163839, 0, 0, 0, 0, 0));             // just inside cutoff
        send_pair(make_pair(163840, 0, 0, 0, 0, 0, 0, 0));             // exactly at cutoff
        send_pair(make_pair(-300000, 0, 0, 300000, 0, 0, 0, 0));       // wraps up
        send_pair(make_pair(0, 300000, 0, 0, -300000, 0, 0, 0));       // wraps down
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 0));                  // saturating force
        send_pair(make_pair(-1, -1, -1, 0, 0, 0, 0, 0));
        send_pair(make_pair(mx, 0, 0, mx - 40000, 0, 0, 0, 0));
        send_pair(make_pair(mn, mn, 0, mn + 50000, mn + 30000, 0, 0, 1));
        send_pair('{40000, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 1, 0});
        send_pair('{0, 40000, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 0, 1});
        send_pair('{0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 1, 1});
    endtask

    // pair lists with random content under one box and cutoff setting
    task automatic test_random(logic [30:0] box, logic [30:0] cut, int count, int reach);
        int len, n;
        write_reg(REG_BOX_LENGTH, box);
        write_reg(REG_CUTOFF_RADIUS, cut);
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                send_pair(random_pair(i == 0 || $urandom_range(0, 30) == 0,
                                      i == len - 1, reach));
                n++;
            end
        end
    endtask

    // stall the receiver long enough to back up the input
    task automatic test_backpressure();
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++) send_pair(random_pair(i == 0, i == 19, 150000));
    endtask

    // fast stretch with no gaps on either side
    task automatic test_streaming();
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) send_pair(random_pair(i == 0, i == 39, 200000));
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(31'd655360, 31'd163840, 120, 200000);
        test_random(31'd1, 31'd1, 40, 200000);
        test_random(CfgMax, CfgMax, 80, 100000);
        test_random(31'd200000, 31'd300000, 100, 150000);
        test_random(CfgMax, 31'd163840, 60, 200000);
        test_random(31'd400000, CfgMax, 80, 300000);
        test_backpressure();
        test_streaming();
        test_random(31'd655360, 31'd163840, 60, 200000);
        in_valid <= 1'b0;
        @(posedge clk);
        while (force_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
